// ----- rtl/lpfm_pkg.sv -----
// Package with request and status codes, the sequencer state type, the rank pass mode and the port widths.
`timescale 1ns / 1ps
`default_nettype none
package lpfm_pkg;
  typedef enum logic [1:0] {
    REQ_ACCESS = 2'd0,
    REQ_UNPIN  = 2'd1,
    REQ_DIRTY  = 2'd2,
    REQ_RELEASE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_MISS     = 2'd1,
    ST_NO_FRAME = 2'd2,
    ST_ABSENT   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_VICTIM,
    S_RANK,
    S_OUT
  } state_e;

  // What a rank update pass does to the other valid frames.
  typedef enum logic [1:0] {
    RM_TOUCH,
    RM_INSERT,
    RM_DROP
  } rank_mode_e;

  localparam int unsigned InWidth  = 48;
  localparam int unsigned OutWidth = 48;
endpackage
`default_nettype wire

// ----- rtl/lru_pinned_frame_manager.sv -----
// Top level of the pinned LRU frame manager.
//
// Usage: one request item enters on the s_axis group (tdata packs req_type,
// table_id, page_num, pin_it from bit 0 up). Exactly one result item leaves
// on the m_axis group for every request.
// The block works on one item at a time. A shared tag/rank compare unit
// walks the frames one per cycle: a lookup scan, a decide step, an
// optional victim scan and a second decide step on a miss with no free
// frame, and rank update passes (one, or two on a victim refill).
// Unpin, mark-dirty and absent pages run the lookup scan and decide step
// only; hits, free-frame fills and present releases add one rank pass; a
// miss with every frame pinned adds the victim scan and second decide; an
// evicting miss adds both of those and two rank passes.
// s_axis_tready is high only while idle.
// Reset clears all valid, pin, dirty and rank state and fills the free list
// with frames 0 to NUM_FRAMES-1 in order; tags need no reset.
// A stalled receiver holds the result in the output register; the block
// accepts no new item until that result is taken.
`timescale 1ns / 1ps
`default_nettype none
module lru_pinned_frame_manager #(
  parameter int unsigned NUM_FRAMES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // req_type[1:0], table_id[9:2], page_num[41:10], pin_it[42], zero fill
  input  wire logic [lpfm_pkg::InWidth-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // status[1:0], frame[5:2], read_needed[6], write_back[7],
  // victim_table[15:8], victim_page[47:16]
  output logic [lpfm_pkg::OutWidth-1:0]      m_axis_tdata
);
  import lpfm_pkg::*;

  localparam int unsigned IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned CW = $clog2(NUM_FRAMES + 1);
  localparam logic [IW-1:0] LastIdx = IW'(NUM_FRAMES - 1);

  logic [NUM_FRAMES-1:0] valid_q, pinned_q, dirty_q;
  logic [IW-1:0] rank_q [NUM_FRAMES];
  logic [7:0]  tbl_mem  [NUM_FRAMES];
  logic [31:0] page_mem [NUM_FRAMES];
  logic [IW-1:0] fifo_q [NUM_FRAMES];
  logic [IW-1:0] head_q, tail_q;
  logic [CW-1:0] count_q;

  state_e state_q, state_d;
  logic [IW-1:0] idx_q;
  logic [1:0]  req_q;
  logic [7:0]  tbl_q;
  logic [31:0] pg_q;
  logic        pin_q;
  logic        found_q;
  logic [IW-1:0] f_q;
  logic        vscan_q;
  logic        vfound_q;
  logic [IW-1:0] best_q;
  rank_mode_e  mode_q;
  logic [IW-1:0] ref_rank_q;
  logic [1:0]  status_q;
  logic [IW-1:0] frame_q;
  logic        rd_q, wb_q;
  logic [7:0]  vt_q;
  logic [31:0] vp_q;

  // Shared compare unit: one frame per cycle.
  logic [7:0]  rd_tbl;
  logic [31:0] rd_pg;
  logic        tag_hit;
  assign rd_tbl  = tbl_mem[idx_q];
  assign rd_pg   = page_mem[idx_q];
  assign tag_hit = valid_q[idx_q] && rd_tbl == tbl_q && rd_pg == pg_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (s_axis_tvalid) state_d = S_SCAN;
      S_SCAN:   if (idx_q == LastIdx) state_d = S_DECIDE;
      S_DECIDE: begin
        state_d = S_OUT;
        if (req_q == REQ_ACCESS) begin
          if (found_q || count_q != '0) state_d = S_RANK;
          else if (!vscan_q) state_d = S_VICTIM;
          else if (vfound_q) state_d = S_RANK;
        end else if (found_q && req_q == REQ_RELEASE) begin
          state_d = S_RANK;
        end
      end
      S_VICTIM: if (idx_q == LastIdx) state_d = S_DECIDE;
      S_RANK: begin
        // A victim refill runs a drop pass and then an insert pass.
        if (idx_q == LastIdx && !(status_q == ST_MISS && mode_q == RM_DROP))
          state_d = S_OUT;
      end
      S_OUT:    if (m_axis_tready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {vp_q, vt_q, wb_q, rd_q, 4'(frame_q), status_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      pinned_q <= '0;
      dirty_q  <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        rank_q[i] <= '0;
        fifo_q[i] <= IW'(i);
      end
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= CW'(NUM_FRAMES);
      idx_q    <= '0;
      found_q  <= 1'b0;
      vscan_q  <= 1'b0;
      vfound_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_q   <= s_axis_tdata[1:0];
            tbl_q   <= s_axis_tdata[9:2];
            pg_q    <= s_axis_tdata[41:10];
            pin_q   <= s_axis_tdata[42];
            idx_q   <= '0;
            found_q <= 1'b0;
            vscan_q <= 1'b0;
            vfound_q <= 1'b0;
            status_q <= ST_DONE;
            frame_q <= '0;
            rd_q <= 1'b0; wb_q <= 1'b0; vt_q <= '0; vp_q <= '0;
          end
        end
        S_SCAN: begin
          if (tag_hit && !found_q) begin
            found_q <= 1'b1;
            f_q     <= idx_q;
          end
          idx_q <= (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
        end
        S_VICTIM: begin
          if (valid_q[idx_q] && !pinned_q[idx_q] &&
              (!vfound_q || rank_q[idx_q] > best_q[IW-1:0])) begin
            vfound_q <= 1'b1;
            f_q      <= idx_q;
            best_q   <= rank_q[idx_q];
          end
          idx_q <= (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
        end
        S_DECIDE: begin
          idx_q   <= '0;
          if (req_q == REQ_ACCESS) begin
            if (found_q) begin
              if (pin_q) pinned_q[f_q] <= 1'b1;
              frame_q <= f_q; ref_rank_q <= rank_q[f_q]; mode_q <= RM_TOUCH;
            end else if (count_q != '0) begin
              fifo_pop: begin
                tbl_mem[fifo_q[head_q]]  <= tbl_q;
                page_mem[fifo_q[head_q]] <= pg_q;
                dirty_q[fifo_q[head_q]]  <= 1'b0;
                pinned_q[fifo_q[head_q]] <= pin_q;
                f_q     <= fifo_q[head_q];
                frame_q <= fifo_q[head_q];
                head_q  <= (head_q == LastIdx) ? '0 : head_q + 1'b1;
                count_q <= count_q - 1'b1;
                status_q <= ST_MISS; rd_q <= 1'b1;
                mode_q  <= RM_INSERT;
              end
            end else if (!vscan_q) begin
              // No free frame: look for the least recent unpinned page.
              vscan_q <= 1'b1;
            end else if (!vfound_q) begin
              status_q <= ST_NO_FRAME;
            end else begin
              // Victim found: drop it from the order, then insert as new.
              wb_q <= dirty_q[f_q];
              if (dirty_q[f_q]) begin
                vt_q <= tbl_mem[f_q]; vp_q <= page_mem[f_q];
              end
              tbl_mem[f_q]  <= tbl_q;
              page_mem[f_q] <= pg_q;
              dirty_q[f_q]  <= 1'b0;
              pinned_q[f_q] <= pin_q;
              valid_q[f_q]  <= 1'b0;
              frame_q <= f_q; status_q <= ST_MISS; rd_q <= 1'b1;
              ref_rank_q <= rank_q[f_q];
              mode_q  <= RM_DROP;
            end
          end else if (!found_q) begin
            status_q <= ST_ABSENT;
          end else begin
            frame_q <= f_q;
            unique case (req_q)
              REQ_UNPIN: pinned_q[f_q] <= 1'b0;
              REQ_DIRTY: dirty_q[f_q] <= 1'b1;
              default: begin
                ref_rank_q <= rank_q[f_q];
                if (pinned_q[f_q]) begin
                  pinned_q[f_q] <= 1'b0;
                  mode_q <= RM_TOUCH;
                end else begin
                  wb_q <= dirty_q[f_q];
                  if (dirty_q[f_q]) begin
                    vt_q <= tbl_mem[f_q]; vp_q <= page_mem[f_q];
                  end
                  dirty_q[f_q] <= 1'b0;
                  valid_q[f_q] <= 1'b0;
                  if (count_q < CW'(NUM_FRAMES)) begin
                    fifo_q[tail_q] <= f_q;
                    tail_q  <= (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
                    count_q <= count_q + 1'b1;
                  end
                  mode_q <= RM_DROP;
                end
              end
            endcase
          end
        end
        S_RANK: begin
          // One frame per cycle through the shared rank compare.
          if (idx_q == f_q) begin
            rank_q[idx_q] <= '0;
          end else if (valid_q[idx_q]) begin
            unique case (mode_q)
              RM_TOUCH:
                if (rank_q[idx_q] < ref_rank_q) rank_q[idx_q] <= rank_q[idx_q] + 1'b1;
              RM_DROP:
                if (rank_q[idx_q] > ref_rank_q) rank_q[idx_q] <= rank_q[idx_q] - 1'b1;
              default: rank_q[idx_q] <= rank_q[idx_q] + 1'b1;
            endcase
          end
          if (idx_q == LastIdx) begin
            // A victim refill, and a plain miss fill, end as a valid MRU entry.
            if (status_q == ST_MISS) begin
              valid_q[f_q] <= 1'b1;
              if (mode_q == RM_DROP) begin
                mode_q <= RM_INSERT;
                idx_q  <= '0;
              end
            end
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/lpfm_checker.sv -----
// Port-level checker for the frame manager, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lpfm_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);
  // Input is never taken while a result is waiting.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  // A held result keeps its data.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
  // A miss always requests a read; other statuses never do.
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6] == (m_axis_tdata[1:0] == 2'd1)))
    else $error("read_needed mismatch");
  // An accepted item leaves the block busy next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accept");
endmodule

bind lru_pinned_frame_manager lpfm_port_checker u_lpfm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// ----- tb/lpfm_checker.sv -----
// Checker that predicts frame manager results and compares them on the output channel.
`timescale 1ns / 1ps
module lpfm_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  input  wire logic                         s_axis_tready,
  input  wire logic [lpfm_pkg::InWidth-1:0] s_axis_tdata,
  input  wire logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  input  wire logic [lpfm_pkg::OutWidth-1:0] m_axis_tdata,
  output int                                fail_count_o,
  output int                                pending_o
);
  import lpfm_pkg::*;
  localparam int NF = 16;

  typedef struct packed {
    logic [31:0] vpage;
    logic [7:0]  vtable;
    logic        wb;
    logic        rd;
    logic [3:0]  frame;
    status_e     status;
  } result_t;

  logic        fr_valid [NF];
  logic [7:0]  fr_table [NF];
  logic [31:0] fr_page  [NF];
  logic        fr_pinned[NF];
  logic        fr_dirty [NF];
  int          fr_rank  [NF];
  int          free_list[$];
  result_t     expected_results[$];

  function automatic int lookup(logic [7:0] tbl, logic [31:0] pg);
    for (int i = 0; i < NF; i++)
      if (fr_valid[i] && fr_table[i] == tbl && fr_page[i] == pg) return i;
    return -1;
  endfunction

  function automatic void make_recent(int f);
    int r;
    r = fr_rank[f];
    for (int i = 0; i < NF; i++)
      if (fr_valid[i] && i != f && fr_rank[i] < r) fr_rank[i]++;
    fr_rank[f] = 0;
  endfunction

  function automatic void drop_frame(int f);
    int r;
    r = fr_rank[f];
    fr_valid[f] = 1'b0;
    for (int i = 0; i < NF; i++)
      if (fr_valid[i] && fr_rank[i] > r) fr_rank[i]--;
    fr_rank[f] = 0;
  endfunction

  function automatic result_t serve_request(logic [lpfm_pkg::InWidth-1:0] d);
    req_e        req;
    logic [7:0]  tbl;
    logic [31:0] pg;
    logic        pin;
    result_t     r;
    int          f, v, best;
    req = req_e'(d[1:0]);
    tbl = d[9:2];
    pg  = d[41:10];
    pin = d[42];
    r   = '0;
    r.status = ST_DONE;
    f = lookup(tbl, pg);
    if (req == REQ_ACCESS) begin
      if (f >= 0) begin
        make_recent(f);
        if (pin) fr_pinned[f] = 1'b1;
        r.frame = f[3:0];
      end else begin
        v = -1;
        best = 0;
        if (free_list.size() > 0) begin
          v = free_list.pop_front();
        end else begin
          for (int i = 0; i < NF; i++)
            if (fr_valid[i] && !fr_pinned[i] && (v < 0 || fr_rank[i] > best)) begin
              v = i;
              best = fr_rank[i];
            end
          if (v >= 0) begin
            if (fr_dirty[v]) begin
              r.wb = 1'b1;
              r.vtable = fr_table[v];
              r.vpage = fr_page[v];
            end
            drop_frame(v);
          end
        end
        if (v < 0) begin
          r.status = ST_NO_FRAME;
        end else begin
          fr_table[v] = tbl;
          fr_page[v] = pg;
          fr_dirty[v] = 1'b0;
          fr_pinned[v] = pin;
          for (int i = 0; i < NF; i++) if (fr_valid[i]) fr_rank[i]++;
          fr_rank[v] = 0;
          fr_valid[v] = 1'b1;
          r.status = ST_MISS;
          r.rd = 1'b1;
          r.frame = v[3:0];
        end
      end
    end else if (f < 0) begin
      r.status = ST_ABSENT;
    end else if (req == REQ_UNPIN) begin
      fr_pinned[f] = 1'b0;
      r.frame = f[3:0];
    end else if (req == REQ_DIRTY) begin
      fr_dirty[f] = 1'b1;
      r.frame = f[3:0];
    end else begin
      r.frame = f[3:0];
      if (fr_pinned[f]) begin
        fr_pinned[f] = 1'b0;
        make_recent(f);
      end else begin
        if (fr_dirty[f]) begin
          r.wb = 1'b1;
          r.vtable = fr_table[f];
          r.vpage = fr_page[f];
        end
        fr_dirty[f] = 1'b0;
        drop_frame(f);
        if (free_list.size() < NF) free_list.push_back(f);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < NF; i++) begin
        fr_valid[i] = 1'b0;
        fr_pinned[i] = 1'b0;
        fr_dirty[i] = 1'b0;
        fr_rank[i] = 0;
        fr_table[i] = '0;
        fr_page[i] = '0;
      end
      free_list.delete();
      for (int i = 0; i < NF; i++) free_list.push_back(i);
      expected_results.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // Check output first: only one item is in flight, so order does not matter.
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata);
        if (expected_results.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10) begin
              $display("mismatch: expected st=%0d fr=%0d rd=%b wb=%b vt=%h vp=%h",
                       want.status, want.frame, want.rd, want.wb, want.vtable,
                       want.vpage);
              $display("          got      st=%0d fr=%0d rd=%b wb=%b vt=%h vp=%h",
                       got.status, got.frame, got.rd, got.wb, got.vtable,
                       got.vpage);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(serve_request(s_axis_tdata));
      pending_o <= expected_results.size();
    end
  end
endmodule

// ----- tb/lru_pinned_frame_manager_tb.sv -----
// Top of the frame manager testbench: stimulus, backpressure and verdict.
`timescale 1ns / 1ps
module lru_pinned_frame_manager_tb;
  import lpfm_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InWidth-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutWidth-1:0] m_axis_tdata;
  int fail_count, pending;

  // Percent chances of idling per cycle for the sender and the receiver.
  int send_idle = 15, recv_idle = 69;
  // When set, the receiver holds tready low regardless of its idle chance.
  bit recv_hold = 1'b0;
  int idle_cycles = 0;

  // Small pool of tags so that hits, evictions and releases happen often.
  logic [7:0]  pool_table[24];
  logic [31:0] pool_page[24];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  lru_pinned_frame_manager dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  lpfm_checker checker_inst (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver decides its tready once per edge with a single assignment.
  always @(posedge clk_i)
    m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle);

  // The watchdog counts cycles in which no item moves on either channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offers one request and holds it until it is accepted. Random idle cycles
  // come before the offer so that gaps land on every phase of the block.
  // tvalid stays high after the accept; idle cycles before the next offer, or a drain, drop it.
  task automatic send_request(req_e req, logic [7:0] tbl, logic [31:0] pg, logic pin);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, pin, pg, tbl, req};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic send_pool_request(int kind_bias);
    int k;
    req_e req;
    k = $urandom_range(23);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: req = REQ_ACCESS;
      5:             req = REQ_UNPIN;
      6, 7:          req = REQ_DIRTY;
      default:       req = REQ_RELEASE;
    endcase
    if (kind_bias > 0 && $urandom_range(9) < kind_bias) begin
      // Noise: fully random tags mostly miss.
      send_request(req_e'($urandom_range(3)), 8'($urandom), $urandom, 1'($urandom));
    end else begin
      send_request(req, pool_table[k], pool_page[k], $urandom_range(3) == 0);
    end
  endtask

  initial begin
    for (int i = 0; i < 24; i++) begin
      pool_table[i] = 8'($urandom);
      pool_page[i] = $urandom;
    end
    pool_table[0] = 8'h00; pool_page[0] = 32'h0000_0000;
    pool_table[1] = 8'hFF; pool_page[1] = 32'hFFFF_FFFF;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: absent pages for every non-access request, then fills, hits and the pin, dirty and release paths.
    send_request(REQ_UNPIN, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_request(REQ_DIRTY, 8'h00, 32'h0, 1'b0);
    send_request(REQ_RELEASE, 8'h12, 32'h3456_789A, 1'b0);
    send_request(REQ_ACCESS, 8'h00, 32'h0, 1'b0);
    send_request(REQ_ACCESS, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_request(REQ_ACCESS, 8'h00, 32'h0, 1'b1);     // hit, pin it
    send_request(REQ_DIRTY, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    send_request(REQ_RELEASE, 8'hFF, 32'hFFFF_FFFF, 1'b0); // pinned: unpin only
    send_request(REQ_RELEASE, 8'hFF, 32'hFFFF_FFFF, 1'b0); // dirty release
    send_request(REQ_UNPIN, 8'h00, 32'h0, 1'b0);
    // Fill all frames pinned, then a miss finds no frame.
    for (int i = 0; i < 16; i++) send_request(REQ_ACCESS, 8'hA0, 32'(i), 1'b1);
    send_request(REQ_ACCESS, 8'hA1, 32'h5, 1'b0);
    for (int i = 0; i < 16; i++) send_request(REQ_RELEASE, 8'hA0, 32'(i), 1'b0);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering items.
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_pool_request(0);
    join
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 15 : (phase == 1) ? 69 : 0;
      recv_idle = (phase == 0) ? 69 : (phase == 1) ? 15 : 0;
      for (int n = 0; n < 260; n++) begin
        // Random dirty/pin-heavy traffic on the pool, with some noise.
        send_pool_request(2);
        if (n == 130) wait_drained();
      end
      wait_drained();
    end

    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
